// File: hw/rtl/pspscr_pkg.sv
// types, constants and codes shared by the program stream pack parser
package pspscr_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned ScrW    = 33;
  localparam int unsigned EventW  = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned SkipW   = 16;
  localparam int unsigned IdxW    = 5;
  localparam int unsigned HistW   = 48;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CfgPackCode   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgSysHdrCode = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgPadCode    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgVideoCode  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgAudioCode  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgEndCode    = 3'd5;

  // reset values of the start code registers
  localparam logic [ByteW-1:0] RstPackCode   = 8'hBA;
  localparam logic [ByteW-1:0] RstSysHdrCode = 8'hBB;
  localparam logic [ByteW-1:0] RstPadCode    = 8'hBE;
  localparam logic [ByteW-1:0] RstVideoCode  = 8'hE0;
  localparam logic [ByteW-1:0] RstAudioCode  = 8'hC0;
  localparam logic [ByteW-1:0] RstEndCode    = 8'hB9;

  localparam logic [IdxW-1:0] V1LastScrIdx  = 5'd4;
  localparam logic [IdxW-1:0] V2LastScrIdx  = 5'd5;
  localparam logic [IdxW-1:0] V1LastIdx     = 5'd7;
  localparam logic [IdxW-1:0] V2StuffIdx    = 5'd9;
  localparam logic [IdxW-1:0] ScrBytes      = 5'd6;

  typedef enum logic [2:0] {
    PH_SCAN = 3'd0,
    PH_CODE = 3'd1,
    PH_PACK = 3'd2,
    PH_LENH = 3'd3,
    PH_LENL = 3'd4,
    PH_SKIP = 3'd5
  } phase_e;

  typedef enum logic [EventW-1:0] {
    EV_PACK    = 2'd0,
    EV_END     = 2'd1,
    EV_UNKNOWN = 2'd2
  } event_e;

  typedef struct packed {
    logic [ByteW-1:0] pack_code;
    logic [ByteW-1:0] sys_hdr_code;
    logic [ByteW-1:0] pad_code;
    logic [ByteW-1:0] video_code;
    logic [ByteW-1:0] audio_code;
    logic [ByteW-1:0] end_code;
  } codes_t;

  typedef struct packed {
    logic [1:0]       prefix_match;
    phase_e           phase;
    logic [IdxW-1:0]  byte_index;
    logic [SkipW-1:0] skip_remaining;
    logic [ByteW-1:0] length_high;
    logic [HistW-1:0] scr_bytes;
    logic             is_v2;
  } parse_t;

  typedef struct packed {
    event_e          event_res;
    logic            version;
    logic [ScrW-1:0] scr;
  } result_t;

endpackage

// File: hw/rtl/pspscr_step.sv
// per-byte parser step: next parser state and optional result
module pspscr_step (
  input  pspscr_pkg::parse_t              st_i,
  input  pspscr_pkg::codes_t              codes_i,
  input  logic [pspscr_pkg::ByteW-1:0]    byte_i,
  output pspscr_pkg::parse_t              st_o,
  output logic                            res_valid_o,
  output pspscr_pkg::result_t             res_o
);

  logic [pspscr_pkg::HistW-1:0] hist;
  logic                         ver_now;
  logic                         is_v1_hdr;
  logic                         is_v2_hdr;
  logic [pspscr_pkg::ScrW-1:0]  scr_v1;
  logic [pspscr_pkg::ScrW-1:0]  scr_v2;
  logic [pspscr_pkg::SkipW-1:0] len;

  assign is_v1_hdr = (byte_i[7:4] == 4'b0010);
  assign is_v2_hdr = (byte_i[7:6] == 2'b01);
  assign hist      = {st_i.scr_bytes[pspscr_pkg::HistW-pspscr_pkg::ByteW-1:0], byte_i};
  assign len       = {st_i.length_high, byte_i};

  // timestamp fields with their marker bits dropped
  assign scr_v1 = {hist[35], hist[34:33], hist[31:24], hist[23:17], hist[15:8], hist[7:1]};
  assign scr_v2 = {hist[45], hist[44:43], hist[41:40], hist[39:32], hist[31:27],
                   hist[25:24], hist[23:16], hist[15:11]};

  always_comb begin
    st_o        = st_i;
    res_valid_o = 1'b0;
    res_o       = '{event_res: pspscr_pkg::EV_PACK, version: 1'b0, scr: '0};
    ver_now     = st_i.is_v2;
    case (st_i.phase)
      pspscr_pkg::PH_CODE: begin
        st_o.prefix_match = 2'd0;
        if (byte_i == codes_i.pack_code) begin
          st_o.phase      = pspscr_pkg::PH_PACK;
          st_o.byte_index = '0;
          st_o.scr_bytes  = '0;
        end else if (byte_i == codes_i.sys_hdr_code || byte_i == codes_i.pad_code ||
                     byte_i == codes_i.video_code || byte_i == codes_i.audio_code) begin
          st_o.phase = pspscr_pkg::PH_LENH;
        end else if (byte_i == codes_i.end_code) begin
          st_o.phase      = pspscr_pkg::PH_SCAN;
          res_valid_o     = 1'b1;
          res_o.event_res = pspscr_pkg::EV_END;
        end else begin
          st_o.phase = pspscr_pkg::PH_SCAN;
        end
      end
      pspscr_pkg::PH_PACK: begin
        if (st_i.byte_index == '0 && !is_v1_hdr && !is_v2_hdr) begin
          // unknown version: the byte goes back to the prefix search
          st_o.phase        = pspscr_pkg::PH_SCAN;
          st_o.prefix_match = (byte_i == '0) ? 2'd1 : 2'd0;
          res_valid_o       = 1'b1;
          res_o.event_res   = pspscr_pkg::EV_UNKNOWN;
        end else begin
          if (st_i.byte_index == '0) begin
            ver_now    = is_v2_hdr && !is_v1_hdr;
            st_o.is_v2 = ver_now;
          end
          if (st_i.byte_index < pspscr_pkg::ScrBytes) begin
            st_o.scr_bytes = hist;
          end
          st_o.byte_index = st_i.byte_index + 1'b1;
          if (!ver_now) begin
            if (st_i.byte_index >= pspscr_pkg::V1LastIdx) begin
              st_o.phase = pspscr_pkg::PH_SCAN;
            end
            if (st_i.byte_index == pspscr_pkg::V1LastScrIdx) begin
              res_valid_o = 1'b1;
              res_o.scr   = scr_v1;
            end
          end else begin
            if (st_i.byte_index >= pspscr_pkg::V2StuffIdx) begin
              if (byte_i[2:0] == 3'd0) begin
                st_o.phase = pspscr_pkg::PH_SCAN;
              end else begin
                st_o.skip_remaining = {{(pspscr_pkg::SkipW-3){1'b0}}, byte_i[2:0]};
                st_o.phase          = pspscr_pkg::PH_SKIP;
              end
            end
            if (st_i.byte_index == pspscr_pkg::V2LastScrIdx) begin
              res_valid_o   = 1'b1;
              res_o.version = 1'b1;
              res_o.scr     = scr_v2;
            end
          end
        end
      end
      pspscr_pkg::PH_LENH: begin
        st_o.length_high = byte_i;
        st_o.phase       = pspscr_pkg::PH_LENL;
      end
      pspscr_pkg::PH_LENL: begin
        if (len == '0) begin
          st_o.phase = pspscr_pkg::PH_SCAN;
        end else begin
          st_o.skip_remaining = len;
          st_o.phase          = pspscr_pkg::PH_SKIP;
        end
      end
      pspscr_pkg::PH_SKIP: begin
        if (st_i.skip_remaining <= 1) begin
          st_o.skip_remaining = '0;
          st_o.phase          = pspscr_pkg::PH_SCAN;
        end else begin
          st_o.skip_remaining = st_i.skip_remaining - 1'b1;
        end
      end
      default: begin
        st_o.phase = pspscr_pkg::PH_SCAN;
        if (byte_i == 8'd0) begin
          if (st_i.prefix_match < 2'd2) begin
            st_o.prefix_match = st_i.prefix_match + 1'b1;
          end
        end else if (byte_i == 8'd1 && st_i.prefix_match >= 2'd2) begin
          st_o.prefix_match = 2'd0;
          st_o.phase        = pspscr_pkg::PH_CODE;
        end else begin
          st_o.prefix_match = 2'd0;
        end
      end
    endcase
  end

endmodule

// File: hw/rtl/program_stream_pack_scr_parser.sv
// top level of the program stream pack header and scr parser
//
//  channel | direction | handshake                | payload
//  in      | to block  | in_valid_i / in_stall_o  | data_byte_i
//  out     | from block| out_valid_o / out_stall_i| event_res_o, version_o, scr_o
//  cfg     | to block  | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// one byte a cycle while in_stall_o is low; a byte passes from the input register
// through the step logic, and its result (if any) is written to the output register
// the input register refills while a result waits; in_stall_o rises only when
// a byte is held and the output register is full and stalled
// reset clears the parser state and loads the default start codes
module program_stream_pack_scr_parser (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [pspscr_pkg::ByteW-1:0]       data_byte_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [pspscr_pkg::EventW-1:0]      event_res_o,
  output logic                               version_o,
  output logic [pspscr_pkg::ScrW-1:0]        scr_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [pspscr_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [pspscr_pkg::ByteW-1:0]       cfg_data_i
);

  logic                          in_valid_q;
  logic [pspscr_pkg::ByteW-1:0]  in_byte_q;
  logic                          out_free;
  logic                          advance;
  logic                          load_in;
  logic                          out_valid_q;
  pspscr_pkg::result_t           out_q;
  pspscr_pkg::parse_t            st_q;
  pspscr_pkg::parse_t            st_d;
  pspscr_pkg::codes_t            codes_q;
  logic                          res_valid;
  pspscr_pkg::result_t           res;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign advance     = in_valid_q && out_free;
  assign in_stall_o  = in_valid_q && !out_free;
  assign load_in     = !in_stall_o;
  assign cfg_ready_o = 1'b1;

  pspscr_step u_step (
    .st_i        (st_q),
    .codes_i     (codes_q),
    .byte_i      (in_byte_q),
    .st_o        (st_d),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (load_in) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_in && in_valid_i) begin
      in_byte_q <= data_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{phase: pspscr_pkg::PH_SCAN, default: '0};
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codes_q.pack_code    <= pspscr_pkg::RstPackCode;
      codes_q.sys_hdr_code <= pspscr_pkg::RstSysHdrCode;
      codes_q.pad_code     <= pspscr_pkg::RstPadCode;
      codes_q.video_code   <= pspscr_pkg::RstVideoCode;
      codes_q.audio_code   <= pspscr_pkg::RstAudioCode;
      codes_q.end_code     <= pspscr_pkg::RstEndCode;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        pspscr_pkg::CfgPackCode:   codes_q.pack_code    <= cfg_data_i;
        pspscr_pkg::CfgSysHdrCode: codes_q.sys_hdr_code <= cfg_data_i;
        pspscr_pkg::CfgPadCode:    codes_q.pad_code     <= cfg_data_i;
        pspscr_pkg::CfgVideoCode:  codes_q.video_code   <= cfg_data_i;
        pspscr_pkg::CfgAudioCode:  codes_q.audio_code   <= cfg_data_i;
        pspscr_pkg::CfgEndCode:    codes_q.end_code     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign event_res_o = out_q.event_res;
  assign version_o   = out_q.version;
  assign scr_o       = out_q.scr;

endmodule

// File: hw/rtl/pspscr_checker.sv
// port level checks for the pack header parser, bound to the top level
module pspscr_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [pspscr_pkg::EventW-1:0]  event_res_o,
  input logic                           version_o,
  input logic [pspscr_pkg::ScrW-1:0]    scr_o
);

  // a stalled result stays offered
  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(event_res_o) && $stable(version_o) && $stable(scr_o))
    else $error("stalled result changed");

  // end and unknown-version events carry no timestamp
  a_event_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o != pspscr_pkg::EV_PACK |-> !version_o && scr_o == '0)
    else $error("non-pack event with version or scr set");

  // input back-pressure only comes from a full, stalled output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

endmodule

bind program_stream_pack_scr_parser pspscr_checker u_pspscr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .event_res_o (event_res_o),
  .version_o   (version_o),
  .scr_o       (scr_o)
);

// File: sim/tb_program_stream_pack_scr_parser.sv
// testbench for the program stream pack header and scr parser
`timescale 1ns / 1ps

module tb_program_stream_pack_scr_parser;

  localparam int DrainCycles = 6;
  localparam int StallLimit  = 2000;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            in_valid_i;
  logic                            in_stall_o;
  logic [pspscr_pkg::ByteW-1:0]    data_byte_i;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  logic [pspscr_pkg::EventW-1:0]   event_res_o;
  logic                            version_o;
  logic [pspscr_pkg::ScrW-1:0]     scr_o;
  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [pspscr_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [pspscr_pkg::ByteW-1:0]    cfg_data_i;

  program_stream_pack_scr_parser uut (.*);

  always #4 clk_i = ~clk_i;

  // parser tracking state
  pspscr_pkg::codes_t   codes;
  logic [1:0]           zero_run;
  pspscr_pkg::phase_e   phase;
  logic [4:0]           pack_idx;
  logic [16:0]          skip_left;
  logic [7:0]           len_hi;
  logic [47:0]          ts_bytes;
  logic                 mpeg2;
  pspscr_pkg::result_t  due_events[$];

  int                   mismatches = 0;
  int                   sent_items = 0;
  int                   send_idle_pct = 0;
  int                   recv_idle_pct = 0;
  pspscr_pkg::result_t  want;

  function automatic pspscr_pkg::codes_t default_codes();
    pspscr_pkg::codes_t c;
    c.pack_code    = pspscr_pkg::RstPackCode;
    c.sys_hdr_code = pspscr_pkg::RstSysHdrCode;
    c.pad_code     = pspscr_pkg::RstPadCode;
    c.video_code   = pspscr_pkg::RstVideoCode;
    c.audio_code   = pspscr_pkg::RstAudioCode;
    c.end_code     = pspscr_pkg::RstEndCode;
    return c;
  endfunction

  function automatic logic [pspscr_pkg::ScrW-1:0] scr_mpeg1(input logic [47:0] h);
    return {h[35], h[34:33], h[31:24], h[23:17], h[15:8], h[7:1]};
  endfunction

  function automatic logic [pspscr_pkg::ScrW-1:0] scr_mpeg2(input logic [47:0] h);
    return {h[45], h[44:43], h[41:40], h[39:32], h[31:27], h[25:24], h[23:16], h[15:11]};
  endfunction

  // mostly random, with zeros, ones and 0xff favoured so prefixes show up inside packets
  function automatic logic [7:0] stream_byte();
    int r;
    r = $urandom_range(0, 15);
    if (r < 2) return 8'h00;
    if (r < 4) return 8'hFF;
    if (r == 4) return 8'h01;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic queue_event(input pspscr_pkg::event_e ev, input logic ver,
                             input logic [pspscr_pkg::ScrW-1:0] scr);
    pspscr_pkg::result_t r;
    r.event_res = ev;
    r.version   = ver;
    r.scr       = scr;
    due_events.push_back(r);
  endtask

  task automatic scan_for_prefix(input logic [7:0] b);
    if (b == 8'h00) begin
      if (zero_run < 2'd2) zero_run = zero_run + 2'd1;
    end else if (b == 8'h01 && zero_run >= 2'd2) begin
      zero_run = 2'd0;
      phase = pspscr_pkg::PH_CODE;
    end else begin
      zero_run = 2'd0;
    end
  endtask

  task automatic track_stream_byte(input logic [7:0] b);
    logic [4:0]  k;
    logic [15:0] len;
    case (phase)
      pspscr_pkg::PH_CODE: begin
        zero_run = 2'd0;
        if (b == codes.pack_code) begin
          phase = pspscr_pkg::PH_PACK;
          pack_idx = 5'd0;
          ts_bytes = '0;
        end else if (b == codes.sys_hdr_code || b == codes.pad_code ||
                     b == codes.video_code || b == codes.audio_code) begin
          phase = pspscr_pkg::PH_LENH;
        end else if (b == codes.end_code) begin
          phase = pspscr_pkg::PH_SCAN;
          queue_event(pspscr_pkg::EV_END, 1'b0, '0);
        end else begin
          phase = pspscr_pkg::PH_SCAN;
        end
      end
      pspscr_pkg::PH_PACK: begin
        k = pack_idx;
        if (k == 5'd0 && b[7:4] != 4'b0010 && b[7:6] != 2'b01) begin
          // unknown version: the byte goes back to the prefix search
          phase = pspscr_pkg::PH_SCAN;
          zero_run = 2'd0;
          scan_for_prefix(b);
          queue_event(pspscr_pkg::EV_UNKNOWN, 1'b0, '0);
        end else begin
          if (k == 5'd0) mpeg2 = (b[7:6] == 2'b01);
          if (k < 5'd6) ts_bytes = {ts_bytes[39:0], b};
          pack_idx = k + 5'd1;
          if (!mpeg2) begin
            if (k >= 5'd7) phase = pspscr_pkg::PH_SCAN;
            if (k == 5'd4) queue_event(pspscr_pkg::EV_PACK, 1'b0, scr_mpeg1(ts_bytes));
          end else begin
            if (k >= 5'd9) begin
              if (b[2:0] == 3'd0) begin
                phase = pspscr_pkg::PH_SCAN;
              end else begin
                skip_left = 17'(b[2:0]);
                phase = pspscr_pkg::PH_SKIP;
              end
            end
            if (k == 5'd5) queue_event(pspscr_pkg::EV_PACK, 1'b1, scr_mpeg2(ts_bytes));
          end
        end
      end
      pspscr_pkg::PH_LENH: begin
        len_hi = b;
        phase = pspscr_pkg::PH_LENL;
      end
      pspscr_pkg::PH_LENL: begin
        len = {len_hi, b};
        if (len == 16'd0) begin
          phase = pspscr_pkg::PH_SCAN;
        end else begin
          skip_left = 17'(len);
          phase = pspscr_pkg::PH_SKIP;
        end
      end
      pspscr_pkg::PH_SKIP: begin
        if (skip_left != 17'd0) skip_left = skip_left - 17'd1;
        if (skip_left == 17'd0) phase = pspscr_pkg::PH_SCAN;
      end
      default: begin
        phase = pspscr_pkg::PH_SCAN;
        scan_for_prefix(b);
      end
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    track_stream_byte(b);
    sent_items++;
    @(negedge clk_i);
  endtask

  task automatic send_start(input logic [7:0] code);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(code);
  endtask

  // wait for every result, then let the pipeline empty
  task automatic settle();
    in_valid_i <= 1'b0;
    while (due_events.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [pspscr_pkg::CfgIdxW-1:0] idx, input logic [7:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      pspscr_pkg::CfgPackCode:   codes.pack_code    = v;
      pspscr_pkg::CfgSysHdrCode: codes.sys_hdr_code = v;
      pspscr_pkg::CfgPadCode:    codes.pad_code     = v;
      pspscr_pkg::CfgVideoCode:  codes.video_code   = v;
      pspscr_pkg::CfgAudioCode:  codes.audio_code   = v;
      pspscr_pkg::CfgEndCode:    codes.end_code     = v;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic write_codes(input pspscr_pkg::codes_t c);
    settle();
    write_reg(pspscr_pkg::CfgPackCode, c.pack_code);
    write_reg(pspscr_pkg::CfgSysHdrCode, c.sys_hdr_code);
    write_reg(pspscr_pkg::CfgPadCode, c.pad_code);
    write_reg(pspscr_pkg::CfgVideoCode, c.video_code);
    write_reg(pspscr_pkg::CfgAudioCode, c.audio_code);
    write_reg(pspscr_pkg::CfgEndCode, c.end_code);
    cfg_valid_i <= 1'b0;
  endtask

  // well-formed packs and packets with random content, plus some noise
  task automatic feed_random_stream(input int target);
    int          stop_at;
    int          pick;
    int          n;
    logic [7:0]  r;
    logic [7:0]  b;
    logic [7:0]  code;
    logic [15:0] len;
    stop_at = sent_items + target;
    while (sent_items < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        n = $urandom_range(1, 6);
        repeat (n) send_byte(stream_byte());
      end else begin
        n = $urandom_range(0, 2);
        repeat (n) send_byte(8'h00);
        r = 8'($urandom_range(0, 255));
        if (pick < 35) begin
          send_start(codes.pack_code);
          send_byte({4'b0010, r[3:0]});
          repeat (7) send_byte(stream_byte());
        end else if (pick < 60) begin
          send_start(codes.pack_code);
          send_byte({2'b01, r[5:0]});
          repeat (8) send_byte(stream_byte());
          b = 8'($urandom_range(0, 255));
          send_byte(b);
          repeat (b[2:0]) send_byte(stream_byte());
        end else if (pick < 78) begin
          case (r[1:0])
            2'd0: code = codes.sys_hdr_code;
            2'd1: code = codes.pad_code;
            2'd2: code = codes.video_code;
            default: code = codes.audio_code;
          endcase
          if ($urandom_range(0, 19) == 0) len = 16'($urandom_range(256, 300));
          else len = 16'($urandom_range(0, 24));
          send_start(code);
          send_byte(len[15:8]);
          send_byte(len[7:0]);
          repeat (len) send_byte(stream_byte());
        end else if (pick < 86) begin
          send_start(codes.end_code);
        end else if (pick < 93) begin
          b = (r[7:6] == 2'd0) ? 8'h00 : r;
          while (b[7:4] == 4'b0010 || b[7:6] == 2'b01) b = 8'($urandom_range(0, 255));
          send_start(codes.pack_code);
          send_byte(b);
        end else begin
          b = stream_byte();
          while (b == codes.pack_code || b == codes.sys_hdr_code || b == codes.pad_code ||
                 b == codes.video_code || b == codes.audio_code || b == codes.end_code)
            b = stream_byte();
          send_start(b);
        end
      end
    end
  endtask

  task automatic test_default_codes();
    send_idle_pct = 34;
    recv_idle_pct = 63;
    // mpeg-1 pack with every timestamp bit set
    send_start(pspscr_pkg::RstPackCode);
    send_byte(8'h2F);
    repeat (7) send_byte(8'hFF);
    // unknown version byte 00 opens the prefix of the end code
    send_start(pspscr_pkg::RstPackCode);
    send_start(pspscr_pkg::RstEndCode);
    // zero length system header
    send_start(pspscr_pkg::RstSysHdrCode);
    send_byte(8'h00);
    send_byte(8'h00);
    feed_random_stream(200);
  endtask

  task automatic test_random_codes();
    pspscr_pkg::codes_t c;
    send_idle_pct = 63;
    recv_idle_pct = 34;
    c.pack_code    = 8'($urandom_range(0, 255));
    c.sys_hdr_code = 8'($urandom_range(0, 255));
    c.pad_code     = 8'($urandom_range(0, 255));
    c.video_code   = 8'($urandom_range(0, 255));
    c.audio_code   = 8'($urandom_range(0, 255));
    c.end_code     = 8'($urandom_range(0, 255));
    write_codes(c);
    feed_random_stream(200);
  endtask

  // extreme values with overlaps, so the match priority matters
  task automatic test_extreme_codes();
    pspscr_pkg::codes_t c;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    c.pack_code    = 8'h00;
    c.sys_hdr_code = 8'hFF;
    c.pad_code     = 8'hFF;
    c.video_code   = 8'h01;
    c.audio_code   = 8'h00;
    c.end_code     = 8'hFF;
    write_codes(c);
    feed_random_stream(200);
  endtask

  task automatic test_long_packets();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_codes(default_codes());
    // mpeg-2 pack, all timestamp bits set, seven stuffing bytes
    send_start(codes.pack_code);
    send_byte(8'h7F);
    repeat (16) send_byte(8'hFF);
    // padding packet whose length uses both length bytes
    send_start(codes.pad_code);
    send_byte(8'h01);
    send_byte(8'h04);
    repeat (260) send_byte(stream_byte());
    feed_random_stream(200);
  endtask

  always @(negedge clk_i) out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_events.size() == 0) begin
        $display("%0t ns: expected no result, actual event_res %0d version %0d scr 0x%09h",
                 $time, event_res_o, version_o, scr_o);
        mismatches++;
      end else begin
        want = due_events.pop_front();
        if (want.event_res !== event_res_o) begin
          $display("%0t ns: event_res expected %0d actual %0d",
                   $time, want.event_res, event_res_o);
          mismatches++;
        end
        if (want.version !== version_o) begin
          $display("%0t ns: version expected %0d actual %0d", $time, want.version, version_o);
          mismatches++;
        end
        if (want.scr !== scr_o) begin
          $display("%0t ns: scr expected 0x%09h actual 0x%09h", $time, want.scr, scr_o);
          mismatches++;
        end
      end
    end
  end

  // cycles in which no request moves on any channel
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no progress for %0d cycles at %0t ns", StallLimit, $time);
    $display("FAIL");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    data_byte_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = pspscr_pkg::CfgPackCode;
    cfg_data_i  = '0;
    codes       = default_codes();
    zero_run    = 2'd0;
    phase       = pspscr_pkg::PH_SCAN;
    pack_idx    = '0;
    skip_left   = '0;
    len_hi      = '0;
    ts_bytes    = '0;
    mpeg2       = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_default_codes();
    test_random_codes();
    test_extreme_codes();
    test_long_packets();
    settle();

    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/pspscr_pkg.sv
hw/rtl/pspscr_step.sv
hw/rtl/program_stream_pack_scr_parser.sv
hw/rtl/pspscr_checker.sv
sim/tb_program_stream_pack_scr_parser.sv
